@@ sv/pid_velocity_thrust_controller_top_assert.svh @@
// Assertion macros shared by the velocity controller modules.
`ifndef PID_VELOCITY_THRUST_CONTROLLER_TOP_ASSERT_SVH
`define PID_VELOCITY_THRUST_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define PVTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define PVTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pvtc_pkg.sv @@
// Package: widths, register codes, reset values and helpers of the velocity controller.
package pvtc_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int GAIN_WIDTH  = 24;
    localparam int FRAC_SHIFT  = 16;                       // Q8.16 gain fraction bits
    localparam int DIFF_W      = VALUE_WIDTH + 1;          // exact difference of two values
    localparam int PROD_W      = GAIN_WIDTH + DIFF_W;      // gain times magnitude
    localparam int SCALED_W    = PROD_W - FRAC_SHIFT + 2;  // signed rounded product
    localparam int CMD_W       = SCALED_W + 2;             // exact command sum
    localparam int NUM_REGS    = 6;
    localparam int REG_INDEX_W = $clog2(NUM_REGS);
    localparam int ADDR_W      = REG_INDEX_W + 2;
    localparam int DATA_W      = 32;
    localparam int FLAG_W      = 3;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEGRAL_GAIN = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_CMD_FLOOR     = 3'd3,
        REG_CMD_CEILING   = 3'd4,
        REG_DEADBAND      = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic        [GAIN_WIDTH-1:0]  prop_gain;
        logic        [GAIN_WIDTH-1:0]  integral_gain;
        logic        [GAIN_WIDTH-1:0]  deriv_gain;
        logic signed [VALUE_WIDTH-1:0] command_floor;
        logic signed [VALUE_WIDTH-1:0] command_ceiling;
        logic        [VALUE_WIDTH-2:0] direction_deadband;
    } cfg_t;

    localparam logic [GAIN_WIDTH-1:0]         RESET_PROP_GAIN     = GAIN_WIDTH'(57586);
    localparam logic [GAIN_WIDTH-1:0]         RESET_INTEGRAL_GAIN = GAIN_WIDTH'(456);
    localparam logic [GAIN_WIDTH-1:0]         RESET_DERIV_GAIN    = GAIN_WIDTH'(1013277);
    localparam logic signed [VALUE_WIDTH-1:0] RESET_CMD_FLOOR     = VALUE_WIDTH'(-2048);
    localparam logic signed [VALUE_WIDTH-1:0] RESET_CMD_CEILING   = VALUE_WIDTH'(2048);
    localparam logic [VALUE_WIDTH-2:0]        RESET_DEADBAND      = (VALUE_WIDTH-1)'(20);

    // Thruster flag patterns: bit 0 rear, bit 1 fore a, bit 2 fore b.
    localparam logic [FLAG_W-1:0] FLAGS_OFF     = 3'b000;
    localparam logic [FLAG_W-1:0] FLAGS_FORWARD = 3'b110;
    localparam logic [FLAG_W-1:0] FLAGS_REVERSE = 3'b001;

    // Ceiling tested first: floor > ceiling yields ceiling if v > ceiling, else floor.
    function automatic logic signed [VALUE_WIDTH-1:0] clamp_limits(
        input logic signed [CMD_W-1:0]       v,
        input logic signed [VALUE_WIDTH-1:0] floor_v,
        input logic signed [VALUE_WIDTH-1:0] ceil_v
    );
        logic signed [VALUE_WIDTH-1:0] r;
        if (v > CMD_W'(ceil_v))
            r = ceil_v;
        else if (v < CMD_W'(floor_v))
            r = floor_v;
        else
            r = v[VALUE_WIDTH-1:0];
        return r;
    endfunction

endpackage

@@ sv/pvtc_scale.sv @@
// Gain times signed value, rounded half away from zero back to the value format.
module pvtc_scale (
    input  logic        [pvtc_pkg::GAIN_WIDTH-1:0] gain,
    input  logic signed [pvtc_pkg::DIFF_W-1:0]     x,
    output logic signed [pvtc_pkg::SCALED_W-1:0]   y
);
    import pvtc_pkg::*;

    logic                  neg;
    logic [DIFF_W-1:0]     mag;
    logic [PROD_W-1:0]     prod;
    logic [PROD_W:0]       rounded;
    logic [SCALED_W-1:0]   q;

    always_comb
    begin
        neg     = x[DIFF_W-1];
        mag     = neg ? DIFF_W'(-x) : DIFF_W'(x);
        prod    = PROD_W'(gain) * PROD_W'(mag);
        rounded = {1'b0, prod} + (PROD_W+1)'(1 << (FRAC_SHIFT - 1));
        q       = SCALED_W'(rounded[PROD_W:FRAC_SHIFT]);
        y       = neg ? -$signed(q) : $signed(q);
    end

endmodule

@@ sv/pvtc_apb_regs.sv @@
// APB configuration registers of the velocity controller.
module pvtc_apb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pvtc_pkg::ADDR_W-1:0]   paddr,
    input  logic [pvtc_pkg::DATA_W-1:0]   pwdata,
    output logic [pvtc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output pvtc_pkg::cfg_t                cfg
);
    import pvtc_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain          <= RESET_PROP_GAIN;
            cfg_reg.integral_gain      <= RESET_INTEGRAL_GAIN;
            cfg_reg.deriv_gain         <= RESET_DERIV_GAIN;
            cfg_reg.command_floor      <= RESET_CMD_FLOOR;
            cfg_reg.command_ceiling    <= RESET_CMD_CEILING;
            cfg_reg.direction_deadband <= RESET_DEADBAND;
        end
        else if (wr_en)
        begin
            case (index)
                REG_PROP_GAIN:     cfg_reg.prop_gain          <= pwdata[GAIN_WIDTH-1:0];
                REG_INTEGRAL_GAIN: cfg_reg.integral_gain      <= pwdata[GAIN_WIDTH-1:0];
                REG_DERIV_GAIN:    cfg_reg.deriv_gain         <= pwdata[GAIN_WIDTH-1:0];
                REG_CMD_FLOOR:     cfg_reg.command_floor      <= pwdata[VALUE_WIDTH-1:0];
                REG_CMD_CEILING:   cfg_reg.command_ceiling    <= pwdata[VALUE_WIDTH-1:0];
                REG_DEADBAND:      cfg_reg.direction_deadband <= pwdata[VALUE_WIDTH-2:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_PROP_GAIN:     prdata = DATA_W'(cfg_reg.prop_gain);
            REG_INTEGRAL_GAIN: prdata = DATA_W'(cfg_reg.integral_gain);
            REG_DERIV_GAIN:    prdata = DATA_W'(cfg_reg.deriv_gain);
            REG_CMD_FLOOR:     prdata = DATA_W'(cfg_reg.command_floor);
            REG_CMD_CEILING:   prdata = DATA_W'(cfg_reg.command_ceiling);
            REG_DEADBAND:      prdata = DATA_W'(cfg_reg.direction_deadband);
            default:           prdata = '0;
        endcase
    end

endmodule

@@ sv/pvtc_core.sv @@
// Control law: integral update, command sum, clamping and thruster direction.
`include "pid_velocity_thrust_controller_top_assert.svh"
module pvtc_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  pvtc_pkg::cfg_t                      cfg,
    input  logic signed [pvtc_pkg::DIFF_W-1:0]  err,
    input  logic signed [pvtc_pkg::DIFF_W-1:0]  dmeas,
    output logic signed [pvtc_pkg::VALUE_WIDTH-1:0] command_next,
    output logic [pvtc_pkg::FLAG_W-1:0]         flags_next
);
    import pvtc_pkg::*;

    logic signed [VALUE_WIDTH-1:0] integral_reg;
    logic signed [VALUE_WIDTH-1:0] integral_next;
    logic [FLAG_W-1:0]             flags_reg;
    logic signed [SCALED_W-1:0]    p_term;
    logic signed [SCALED_W-1:0]    i_term;
    logic signed [SCALED_W-1:0]    d_term;
    logic signed [CMD_W-1:0]       integral_sum;
    logic signed [CMD_W-1:0]       command_sum;
    logic signed [VALUE_WIDTH:0]   band_pos;
    logic signed [VALUE_WIDTH:0]   band_neg;
    logic signed [VALUE_WIDTH:0]   command_ext;

    pvtc_scale u_scale_p (.gain(cfg.prop_gain),     .x(err),   .y(p_term));
    pvtc_scale u_scale_i (.gain(cfg.integral_gain), .x(err),   .y(i_term));
    pvtc_scale u_scale_d (.gain(cfg.deriv_gain),    .x(dmeas), .y(d_term));

    always_comb
    begin
        integral_sum  = CMD_W'(integral_reg) + CMD_W'(i_term);
        integral_next = clamp_limits(integral_sum, cfg.command_floor, cfg.command_ceiling);
        command_sum   = CMD_W'(p_term) + CMD_W'(integral_next) - CMD_W'(d_term);
        command_next  = clamp_limits(command_sum, cfg.command_floor, cfg.command_ceiling);

        band_pos    = $signed({2'b00, cfg.direction_deadband});
        band_neg    = -band_pos;
        command_ext = (VALUE_WIDTH+1)'(command_next);
        if (command_ext > band_pos)
            flags_next = FLAGS_FORWARD;
        else if (command_ext < band_neg)
            flags_next = FLAGS_REVERSE;
        else
            flags_next = flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            flags_reg    <= FLAGS_OFF;
        end
        else if (advance)
        begin
            integral_reg <= integral_next;
            flags_reg    <= flags_next;
        end
    end

    `PVTC_ASSERT_NOW(a_cmd_in_limits,
        advance && (cfg.command_floor <= cfg.command_ceiling),
        (command_next >= cfg.command_floor) && (command_next <= cfg.command_ceiling),
        "command outside limits")
    `PVTC_ASSERT_NEXT(a_forward_flags,
        advance && (command_ext > band_pos),
        flags_reg == FLAGS_FORWARD,
        "forward flags not taken")
    `PVTC_ASSERT_NEXT(a_state_holds,
        !advance,
        $stable(integral_reg) && $stable(flags_reg),
        "state changed without an item")

endmodule

@@ sv/pid_velocity_thrust_controller_top.sv @@
// Top level of the velocity PID controller with thruster direction selection.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------------
//  input    | in_valid / in_ready   | target_velocity, sensed_velocity
//  output   | out_valid / out_ready | thrust_command, rear_thruster_on,
//           |                       | fore_thruster_a_on, fore_thruster_b_on
//  config   | APB psel/penable/...  | six registers at byte addresses 4*i
//
// One item per cycle unless out_ready stalls; out_valid marks a full result register.
// The input register holds the error and measurement step; the control law, its three
// gain multipliers and the clamps sit between it and the result register.
// Reset clears the integral, the stored velocity, the thruster flags and both valids.
// A stalled result holds in the result register while the input register still takes
// an item; only when both are full does in_ready drop.
`include "pid_velocity_thrust_controller_top_assert.svh"
module pid_velocity_thrust_controller_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [pvtc_pkg::ADDR_W-1:0]             paddr,
    input  logic [pvtc_pkg::DATA_W-1:0]             pwdata,
    output logic [pvtc_pkg::DATA_W-1:0]             prdata,
    output logic                                    pready,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [pvtc_pkg::VALUE_WIDTH-1:0] target_velocity,
    input  logic signed [pvtc_pkg::VALUE_WIDTH-1:0] sensed_velocity,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [pvtc_pkg::VALUE_WIDTH-1:0] thrust_command,
    output logic                                    rear_thruster_on,
    output logic                                    fore_thruster_a_on,
    output logic                                    fore_thruster_b_on
);
    import pvtc_pkg::*;

    cfg_t                          cfg;
    logic                          s1_valid_reg;
    logic signed [DIFF_W-1:0]      err_reg;
    logic signed [DIFF_W-1:0]      dmeas_reg;
    logic signed [VALUE_WIDTH-1:0] prev_velocity_reg;
    logic                          out_valid_reg;
    logic signed [VALUE_WIDTH-1:0] command_reg;
    logic [FLAG_W-1:0]             flags_out_reg;
    logic signed [VALUE_WIDTH-1:0] command_next;
    logic [FLAG_W-1:0]             flags_next;
    logic                          out_free;
    logic                          advance;
    logic                          in_accept;

    pvtc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pvtc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .cfg          (cfg),
        .err          (err_reg),
        .dmeas        (dmeas_reg),
        .command_next (command_next),
        .flags_next   (flags_next)
    );

    // Advance the held item when the result register is empty or being drained.
    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign in_accept = in_valid && in_ready;

    // Input register: form error and measurement step at acceptance, keep the velocity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            prev_velocity_reg <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg      <= 1'b1;
                prev_velocity_reg <= sensed_velocity;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            err_reg   <= DIFF_W'(target_velocity) - DIFF_W'(sensed_velocity);
            dmeas_reg <= DIFF_W'(sensed_velocity) - DIFF_W'(prev_velocity_reg);
        end
    end

    // Result register: hold while the consumer stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            command_reg   <= command_next;
            flags_out_reg <= flags_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign thrust_command     = command_reg;
    assign rear_thruster_on   = flags_out_reg[0];
    assign fore_thruster_a_on = flags_out_reg[1];
    assign fore_thruster_b_on = flags_out_reg[2];

    `PVTC_ASSERT_NOW(a_no_overwrite,
        s1_valid_reg && out_valid_reg && !out_ready,
        !in_ready,
        "input taken while both stages are full")
    `PVTC_ASSERT_NEXT(a_item_moves_on,
        s1_valid_reg && out_free,
        out_valid_reg,
        "held item did not reach the result register")
    `PVTC_ASSERT_NEXT(a_accept_fills,
        in_valid && in_ready,
        s1_valid_reg,
        "accepted item not held")

endmodule

@@ dv/thrust_command_checker.sv @@
// Checker: predicts every thrust item of the velocity controller and compares the results.
`timescale 1ns / 100ps
module thrust_command_checker
    import pvtc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    input  logic                          pready,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic signed [VALUE_WIDTH-1:0] target_velocity,
    input  logic signed [VALUE_WIDTH-1:0] sensed_velocity,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [VALUE_WIDTH-1:0] thrust_command,
    input  logic                          rear_thruster_on,
    input  logic                          fore_thruster_a_on,
    input  logic                          fore_thruster_b_on,
    output int                            mismatches,
    output int                            pending
);

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] command;
        logic [FLAG_W-1:0]             flags;
    } thrust_result_t;

    thrust_result_t    thrust_expect_q[$];
    thrust_result_t    oldest;
    cfg_t              cfg;
    longint            integral_acc;
    longint            last_sensed;
    logic [FLAG_W-1:0] flag_state;

    initial mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Q8.16 gain times an exact value, rounded half away from zero back to Q4.12.
    function automatic longint apply_gain(input logic [GAIN_WIDTH-1:0] gain, input longint x);
        longint mag;
        longint q;
        mag = (x < 0) ? -x : x;
        q = (longint'(gain) * mag + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        return (x < 0) ? -q : q;
    endfunction

    // Ceiling is tested first.
    function automatic longint clamp_to_limits(input longint v);
        longint lo;
        longint hi;
        lo = longint'($signed(cfg.command_floor));
        hi = longint'($signed(cfg.command_ceiling));
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    task automatic predict_thrust(input logic signed [VALUE_WIDTH-1:0] tgt,
                                  input logic signed [VALUE_WIDTH-1:0] sns);
        longint         err;
        longint         meas_step;
        longint         cmd;
        longint         band;
        thrust_result_t r;
        err       = longint'(tgt) - longint'(sns);
        meas_step = longint'(sns) - last_sensed;
        integral_acc = clamp_to_limits(integral_acc + apply_gain(cfg.integral_gain, err));
        cmd = apply_gain(cfg.prop_gain, err) + integral_acc
              - apply_gain(cfg.deriv_gain, meas_step);
        cmd = clamp_to_limits(cmd);
        band = longint'(cfg.direction_deadband);
        if (cmd > band)
            flag_state = FLAGS_FORWARD;
        else if (cmd < -band)
            flag_state = FLAGS_REVERSE;
        last_sensed = longint'(sns);
        r.command = cmd[VALUE_WIDTH-1:0];
        r.flags   = flag_state;
        thrust_expect_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.prop_gain          = RESET_PROP_GAIN;
            cfg.integral_gain      = RESET_INTEGRAL_GAIN;
            cfg.deriv_gain         = RESET_DERIV_GAIN;
            cfg.command_floor      = RESET_CMD_FLOOR;
            cfg.command_ceiling    = RESET_CMD_CEILING;
            cfg.direction_deadband = RESET_DEADBAND;
            integral_acc = 0;
            last_sensed  = 0;
            flag_state   = FLAGS_OFF;
            thrust_expect_q.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_PROP_GAIN:     cfg.prop_gain          = pwdata[GAIN_WIDTH-1:0];
                    REG_INTEGRAL_GAIN: cfg.integral_gain      = pwdata[GAIN_WIDTH-1:0];
                    REG_DERIV_GAIN:    cfg.deriv_gain         = pwdata[GAIN_WIDTH-1:0];
                    REG_CMD_FLOOR:     cfg.command_floor      = pwdata[VALUE_WIDTH-1:0];
                    REG_CMD_CEILING:   cfg.command_ceiling    = pwdata[VALUE_WIDTH-1:0];
                    REG_DEADBAND:      cfg.direction_deadband = pwdata[VALUE_WIDTH-2:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (thrust_expect_q.size() == 0)
                    report_mismatch($sformatf("result with none outstanding, command %0d",
                                              thrust_command));
                else
                begin
                    oldest = thrust_expect_q.pop_front();
                    if (thrust_command !== oldest.command)
                        report_mismatch($sformatf("thrust_command got %0d want %0d",
                                                  thrust_command, oldest.command));
                    if (rear_thruster_on !== oldest.flags[0])
                        report_mismatch($sformatf("rear_thruster_on got %b want %b",
                                                  rear_thruster_on, oldest.flags[0]));
                    if (fore_thruster_a_on !== oldest.flags[1])
                        report_mismatch($sformatf("fore_thruster_a_on got %b want %b",
                                                  fore_thruster_a_on, oldest.flags[1]));
                    if (fore_thruster_b_on !== oldest.flags[2])
                        report_mismatch($sformatf("fore_thruster_b_on got %b want %b",
                                                  fore_thruster_b_on, oldest.flags[2]));
                end
            end
            if (in_valid && in_ready)
                predict_thrust(target_velocity, sensed_velocity);
            pending <= thrust_expect_q.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
// Testbench top: clock, reset, register writes, sample stimulus and the final verdict.
`timescale 1ns / 100ps
module tb_top;
    import pvtc_pkg::*;

    // Settling wait after the last result before calling the block idle.
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 210;

    logic                          clk                = 1'b0;
    logic                          rst_n              = 1'b0;
    logic                          psel               = 1'b0;
    logic                          penable            = 1'b0;
    logic                          pwrite             = 1'b0;
    logic [ADDR_W-1:0]             paddr              = '0;
    logic [DATA_W-1:0]             pwdata             = '0;
    logic [DATA_W-1:0]             prdata;
    logic                          pready;
    logic                          in_valid           = 1'b0;
    logic                          in_ready;
    logic signed [VALUE_WIDTH-1:0] target_velocity    = '0;
    logic signed [VALUE_WIDTH-1:0] sensed_velocity    = '0;
    logic                          out_valid;
    logic                          out_ready          = 1'b0;
    logic signed [VALUE_WIDTH-1:0] thrust_command;
    logic                          rear_thruster_on;
    logic                          fore_thruster_a_on;
    logic                          fore_thruster_b_on;

    int mismatches;
    int pending;
    int cycle_count = 0;

    // Sender burst state and the tracking trajectory used by most random items.
    int burst_left = 0;
    int track_tgt  = 0;
    int track_sns  = 0;

    // Receiver stall pattern state.
    int rx_mode  = 0;
    int rx_left  = 0;
    int rx_phase = 0;

    pid_velocity_thrust_controller_top u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .target_velocity    (target_velocity),
        .sensed_velocity    (sensed_velocity),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .thrust_command     (thrust_command),
        .rear_thruster_on   (rear_thruster_on),
        .fore_thruster_a_on (fore_thruster_a_on),
        .fore_thruster_b_on (fore_thruster_b_on)
    );

    thrust_command_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .target_velocity    (target_velocity),
        .sensed_velocity    (sensed_velocity),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .thrust_command     (thrust_command),
        .rear_thruster_on   (rear_thruster_on),
        .fore_thruster_a_on (fore_thruster_a_on),
        .fore_thruster_b_on (fore_thruster_b_on),
        .mismatches         (mismatches),
        .pending            (pending)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Guard against a hung handshake: give up well beyond the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: switch between always ready, random stalls, a fixed duty pattern
    // and a mostly stalled mode, each for a random stretch of cycles.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end
        else
            rx_left--;
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 9) < 7);
            2:       out_ready <= (rx_phase % 8 < 5);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        rx_phase++;
    end

    // Write one register with a setup and an access phase. Fill the bits above the
    // register's width with noise, which the block must ignore.
    task automatic apb_write(input logic [REG_INDEX_W-1:0] idx, input longint value,
                             input int width);
        logic [63:0] noise;
        logic [63:0] keep;
        noise = {$urandom(), $urandom()};
        keep  = (64'd1 << width) - 64'd1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'((noise & ~keep) | (64'(value) & keep));
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one item and hold it until accepted. Open a gap only when a burst runs out,
    // so valid is never dropped and raised within the same step.
    task automatic push_sample(input logic signed [VALUE_WIDTH-1:0] tgt,
                               input logic signed [VALUE_WIDTH-1:0] sns);
        int idle;
        if (burst_left == 0)
        begin
            idle       = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 24);
            in_valid <= 1'b0;
            repeat (idle)
                @(negedge clk);
        end
        burst_left--;
        in_valid        <= 1'b1;
        target_velocity <= tgt;
        sensed_velocity <= sns;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold off the sender until every predicted item has come out, then let the
    // pipeline settle so the block is idle for register writes.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [VALUE_WIDTH-1:0] rand_value();
        return VALUE_WIDTH'($urandom());
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] corner_value();
        case ($urandom_range(0, 6))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 32766;
            default: return 32767;
        endcase
    endfunction

    // Mostly a sensed velocity chasing a target, as a real loop sees it; the rest
    // is unrelated noise and corner values.
    task automatic random_sample();
        int kind;
        int delta;
        kind = $urandom_range(0, 99);
        if (kind < 60)
        begin
            if ($urandom_range(0, 31) == 0)
                track_tgt = ($urandom_range(0, 3) == 0) ? int'(rand_value())
                                                        : int'($urandom_range(0, 16384)) - 8192;
            delta = (track_tgt - track_sns) / int'($urandom_range(2, 8))
                    + int'($urandom_range(0, 64)) - 32;
            track_sns = track_sns + delta;
            if (track_sns > 32767)
                track_sns = 32767;
            else if (track_sns < -32768)
                track_sns = -32768;
            push_sample(VALUE_WIDTH'(track_tgt), VALUE_WIDTH'(track_sns));
        end
        else if (kind < 85)
            push_sample(rand_value(), rand_value());
        else
            push_sample(corner_value(), corner_value());
    endtask

    function automatic longint rand_gain();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return (longint'(1) << GAIN_WIDTH) - 1;
            2, 3:    return $urandom_range(0, 131072);
            default: return $urandom() & ((longint'(1) << GAIN_WIDTH) - 1);
        endcase
    endfunction

    // Kind 0 sets every register to its top extreme but the floor to its bottom one, kind 1
    // every register to its bottom one, anything else draws a random setting.
    task automatic randomise_config(input int kind);
        longint lo;
        longint hi;
        longint swap;
        longint band;
        if (kind == 0)
        begin
            apb_write(REG_PROP_GAIN, (longint'(1) << GAIN_WIDTH) - 1, GAIN_WIDTH);
            apb_write(REG_INTEGRAL_GAIN, (longint'(1) << GAIN_WIDTH) - 1, GAIN_WIDTH);
            apb_write(REG_DERIV_GAIN, (longint'(1) << GAIN_WIDTH) - 1, GAIN_WIDTH);
            apb_write(REG_CMD_FLOOR, -32768, VALUE_WIDTH);
            apb_write(REG_CMD_CEILING, 32767, VALUE_WIDTH);
            apb_write(REG_DEADBAND, 32767, VALUE_WIDTH - 1);
        end
        else if (kind == 1)
        begin
            apb_write(REG_PROP_GAIN, 0, GAIN_WIDTH);
            apb_write(REG_INTEGRAL_GAIN, 0, GAIN_WIDTH);
            apb_write(REG_DERIV_GAIN, 0, GAIN_WIDTH);
            apb_write(REG_CMD_FLOOR, -32768, VALUE_WIDTH);
            apb_write(REG_CMD_CEILING, -32768, VALUE_WIDTH);
            apb_write(REG_DEADBAND, 0, VALUE_WIDTH - 1);
        end
        else
        begin
            apb_write(REG_PROP_GAIN, rand_gain(), GAIN_WIDTH);
            apb_write(REG_INTEGRAL_GAIN, rand_gain(), GAIN_WIDTH);
            apb_write(REG_DERIV_GAIN, rand_gain(), GAIN_WIDTH);
            lo = rand_value();
            hi = rand_value();
            case ($urandom_range(0, 5))
                0:
                begin
                    lo = -32768;
                    hi = 32767;
                end
                1: ;  // keep whatever order came out, inverted limits included
                2: hi = lo;
                3:
                begin
                    hi = $urandom_range(256, 8192);
                    lo = -hi;
                end
                default:
                begin
                    if (lo > hi)
                    begin
                        swap = lo;
                        lo   = hi;
                        hi   = swap;
                    end
                end
            endcase
            apb_write(REG_CMD_FLOOR, lo, VALUE_WIDTH);
            apb_write(REG_CMD_CEILING, hi, VALUE_WIDTH);
            case ($urandom_range(0, 3))
                0:       band = 0;
                1:       band = 32767;
                2:       band = $urandom_range(0, 300);
                default: band = $urandom_range(0, 32767);
            endcase
            apb_write(REG_DEADBAND, band, VALUE_WIDTH - 1);
        end
    endtask

    initial
    begin
        // Hold reset, then release it on a falling edge.
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: zero, full-scale errors both ways and small steps either
        // side of the deadband.
        push_sample(0, 0);
        push_sample(32767, -32768);
        push_sample(-32768, 32767);
        push_sample(-32768, -32768);
        push_sample(32767, 32767);
        push_sample(40, 0);
        push_sample(-40, 0);
        push_sample(0, 0);
        drain_results();

        // Largest gains, no derivative, widest limits, no deadband.
        apb_write(REG_PROP_GAIN, (longint'(1) << GAIN_WIDTH) - 1, GAIN_WIDTH);
        apb_write(REG_INTEGRAL_GAIN, (longint'(1) << GAIN_WIDTH) - 1, GAIN_WIDTH);
        apb_write(REG_DERIV_GAIN, 0, GAIN_WIDTH);
        apb_write(REG_CMD_FLOOR, -32768, VALUE_WIDTH);
        apb_write(REG_CMD_CEILING, 32767, VALUE_WIDTH);
        apb_write(REG_DEADBAND, 0, VALUE_WIDTH - 1);
        push_sample(32767, -32768);
        push_sample(-32768, 32767);
        push_sample(1, 0);
        push_sample(0, 0);
        push_sample(-1, 0);
        push_sample(32767, 0);
        drain_results();

        // Lower the ceiling under a saturated integral: the stored value stays until
        // the next item clamps it.
        apb_write(REG_CMD_CEILING, 100, VALUE_WIDTH);
        push_sample(0, 0);
        push_sample(0, 0);
        drain_results();

        // Floor above ceiling, strong derivative, widest deadband so flags hold.
        apb_write(REG_CMD_FLOOR, 1000, VALUE_WIDTH);
        apb_write(REG_CMD_CEILING, -1000, VALUE_WIDTH);
        apb_write(REG_DERIV_GAIN, (longint'(1) << GAIN_WIDTH) - 1, GAIN_WIDTH);
        apb_write(REG_DEADBAND, 32767, VALUE_WIDTH - 1);
        push_sample(500, 0);
        push_sample(-500, 0);
        push_sample(0, 32767);
        drain_results();

        // Writes past the last register must leave every setting alone.
        apb_write(REG_INDEX_W'(NUM_REGS), $urandom(), DATA_W);
        apb_write(REG_INDEX_W'(NUM_REGS + 1), $urandom(), DATA_W);
        push_sample(0, 0);
        push_sample(-32768, 0);

        // Random phases, each under fresh settings; the first two take the extremes.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            randomise_config(phase);
            track_tgt = 0;
            track_sns = 0;
            repeat (ITEMS_PER_PHASE)
            begin
                random_sample();
                // Now and then starve the block completely before going on.
                if ($urandom_range(0, 149) == 0)
                    drain_results();
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/pvtc_pkg.sv
sv/pvtc_scale.sv
sv/pvtc_apb_regs.sv
sv/pvtc_core.sv
sv/pid_velocity_thrust_controller_top.sv
dv/thrust_command_checker.sv
dv/tb_top.sv
